// File: hw/rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the shunt monitor calibration block: field
// widths, status codes, divider control and the 1-2-5 step series.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int CUR_W     = 32;
  localparam int RES_W     = 24;
  localparam int PROD_W    = 56;
  localparam int DEN_W     = 37;
  localparam int STEP_W    = 13;
  localparam int LSB_W     = 40;
  localparam int FS_W      = 40;
  localparam int CAL_W     = 15;
  localparam int STATUS_W  = 3;
  localparam int MIN_STEP_W = 18;

  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 38;
  localparam int DIV_CNT_W = 6;

  localparam int LSB_FRAC_SHIFT = 9;
  localparam int FS_SHIFT       = 15;
  localparam int SERIES_N       = 12;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 3'd0,
    STATUS_VSHUNT_HIGH = 3'd1,
    STATUS_CURRENT_LOW = 3'd2,
    STATUS_SHUNT_LOW   = 3'd3,
    STATUS_NORM_FAIL   = 3'd4
  } status_e;

  typedef enum logic {
    CFG_SHUNT     = 1'b0,
    CFG_MIN_SHUNT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctrl_t;

  localparam logic [RES_W-1:0]     SHUNT_RESET     = 24'd100000;
  localparam logic [RES_W-1:0]     MIN_SHUNT_RESET = 24'd1000;

  localparam logic [PROD_W-1:0]    VSHUNT_MAX_PV   = 56'd81900000000;
  localparam logic [CUR_W-1:0]     CURRENT_MIN_UA  = 32'd1000;
  localparam logic [MIN_STEP_W-1:0] MIN_STEP_NUM   = 18'd156250;
  localparam logic [DIV_NUM_W-1:0] CAL_NUM_RAW_X2  = 49'd335544320000000;
  localparam logic [DEN_W-1:0]     CAL_NUM_NORM_X2 = 37'd10240000000;
  localparam logic [DIV_NUM_W-1:0] CAL_MAX         = 49'd32767;
  localparam logic [RES_W-1:0]     PA_PER_UA       = 24'd1000000;
  localparam logic [RES_W-1:0]     RAW_PA_NUM      = 24'd15625;
  localparam logic [STEP_W-1:0]    STEP_MAX        = 13'd5000;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MIN_STEP = 6'd18;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_CAL_NORM = 6'd37;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_CAL_RAW  = 6'd49;

  localparam logic [STEP_W-1:0] SERIES_UA [SERIES_N] = '{
    13'd1, 13'd2, 13'd5, 13'd10, 13'd20, 13'd50,
    13'd100, 13'd200, 13'd500, 13'd1000, 13'd2000, 13'd5000
  };

endpackage

// File: hw/rtl/smc_div.sv
// ----------------------------------------------------------------------------
// smc_div
// Bit-serial restoring divider: one quotient bit per cycle, step count set
// per transaction so that short dividends finish early.
// ----------------------------------------------------------------------------
module smc_div
  import smc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctrl_t            ctrl_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output logic [DIV_NUM_W-1:0] quotient_o,
  output logic                 done_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start && !busy_q) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= ctrl_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: hw/rtl/shunt_monitor_calibration.sv
// ----------------------------------------------------------------------------
// shunt_monitor_calibration
// Computes the calibration word, current step and full-scale current of a
// shunt current monitor from a requested full-scale current.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and the result
// is valid on the result ports while done_o is high for exactly one cycle; the
// receiver cannot stall, so capture it then. The bit-serial divider sets the
// run time: 49 quotient bits for the exact step, 18 plus 37 with normalize,
// then the calibration word is halved until it fits (up to 23 halvings for
// the exact step, at most one with normalize). A rejected request or a failed
// normalize returns zero results with its status code.
// Configuration writes are taken only while busy is low.
module shunt_monitor_calibration
  import smc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CUR_W-1:0]    max_current_ua_i,
  input  logic                normalize_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [RES_W-1:0]    cfg_data_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [CAL_W-1:0]    calibration_o,
  output logic [LSB_W-1:0]    current_lsb_pa_o,
  output logic [FS_W-1:0]     full_scale_ua_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULV,
    S_CHECK,
    S_DIVB,
    S_STEP,
    S_MULD,
    S_MULL,
    S_LOADC,
    S_DIVC,
    S_HALVE
  } state_e;

  state_e                state_q;
  logic [RES_W-1:0]      shunt_q;
  logic [RES_W-1:0]      min_shunt_q;
  logic [CUR_W-1:0]      cur_q;
  logic                  norm_q;
  logic [PROD_W-1:0]     prod_q;
  logic [DEN_W-1:0]      den_q;
  logic [STEP_W-1:0]     step_q;
  logic [PROD_W-1:0]     lsb_q;
  logic [FS_W-1:0]       fs_q;
  logic [DIV_NUM_W-1:0]  cal_q;
  logic                  done_q;
  status_e               status_q;
  logic [CAL_W-1:0]      cal_out_q;
  logic [LSB_W-1:0]      lsb_out_q;
  logic [FS_W-1:0]       fs_out_q;

  logic [CUR_W-1:0]      mul_a;
  logic [RES_W-1:0]      mul_b;
  logic [PROD_W-1:0]     mul_p;

  div_ctrl_t             div_ctrl;
  logic [DIV_NUM_W-1:0]  div_dividend;
  logic [DIV_DEN_W-1:0]  div_divisor;
  logic [DIV_NUM_W-1:0]  div_quo;
  logic                  div_done;

  logic                  vs_high;
  logic                  cur_low;
  logic                  shunt_low;
  logic [MIN_STEP_W:0]   need_a;
  logic [MIN_STEP_W:0]   need_b;
  logic [MIN_STEP_W:0]   need_s;
  logic [STEP_W-1:0]     step_sel;
  logic                  step_ok;
  logic [DEN_W-1:0]      norm_sum;

  smc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = cur_q;
    mul_b = shunt_q;
    case (state_q)
      S_MULD: begin
        mul_a = CUR_W'(step_q);
      end
      S_MULL: begin
        if (norm_q) begin
          mul_a = CUR_W'(step_q);
          mul_b = PA_PER_UA;
        end else begin
          mul_b = RAW_PA_NUM;
        end
      end
      default: begin
        mul_a = cur_q;
        mul_b = shunt_q;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    vs_high   = (prod_q > VSHUNT_MAX_PV);
    cur_low   = (cur_q < CURRENT_MIN_UA);
    shunt_low = (shunt_q == '0) || (shunt_q < min_shunt_q);

    need_a = (MIN_STEP_W+1)'(cur_q[CUR_W-1:FS_SHIFT]);
    need_b = {1'b0, div_quo[MIN_STEP_W-1:0]};
    need_s = ((need_a > need_b) ? need_a : need_b) + 1'b1;
    step_ok  = (need_s <= (MIN_STEP_W+1)'(STEP_MAX));
    step_sel = STEP_MAX;
    for (int i = SERIES_N - 1; i >= 0; i--) begin
      if ((MIN_STEP_W+1)'(SERIES_UA[i]) >= need_s) begin
        step_sel = SERIES_UA[i];
      end
    end

    norm_sum = CAL_NUM_NORM_X2 + den_q;
  end

  // divider requests
  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.steps = DIV_STEPS_CAL_RAW;
    div_dividend   = CAL_NUM_RAW_X2 + DIV_NUM_W'(den_q);
    div_divisor    = {den_q, 1'b0};
    case (state_q)
      S_CHECK: begin
        div_ctrl.start = norm_q && !vs_high && !cur_low && !shunt_low;
        div_ctrl.steps = DIV_STEPS_MIN_STEP;
        div_dividend   = {MIN_STEP_NUM, (DIV_NUM_W-MIN_STEP_W)'(0)};
        div_divisor    = DIV_DEN_W'(shunt_q);
      end
      S_LOADC: begin
        div_ctrl.start = 1'b1;
        if (norm_q) begin
          div_ctrl.steps = DIV_STEPS_CAL_NORM;
          div_dividend   = {norm_sum, (DIV_NUM_W-DEN_W)'(0)};
        end
      end
      default: begin
        div_ctrl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      shunt_q     <= SHUNT_RESET;
      min_shunt_q <= MIN_SHUNT_RESET;
      cur_q       <= '0;
      norm_q      <= 1'b0;
      prod_q      <= '0;
      den_q       <= '0;
      step_q      <= '0;
      lsb_q       <= '0;
      fs_q        <= '0;
      cal_q       <= '0;
      done_q      <= 1'b0;
      status_q    <= STATUS_OK;
      cal_out_q   <= '0;
      lsb_out_q   <= '0;
      fs_out_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SHUNT:     shunt_q     <= cfg_data_i;
          CFG_MIN_SHUNT: min_shunt_q <= cfg_data_i;
          default:       shunt_q     <= shunt_q;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cur_q   <= max_current_ua_i;
            norm_q  <= normalize_i;
            state_q <= S_MULV;
          end
        end
        S_MULV: begin
          prod_q  <= mul_p;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (vs_high || cur_low || shunt_low) begin
            done_q    <= 1'b1;
            status_q  <= vs_high ? STATUS_VSHUNT_HIGH :
                         cur_low ? STATUS_CURRENT_LOW : STATUS_SHUNT_LOW;
            cal_out_q <= '0;
            lsb_out_q <= '0;
            fs_out_q  <= '0;
            state_q   <= S_IDLE;
          end else if (norm_q) begin
            state_q <= S_DIVB;
          end else begin
            state_q <= S_MULL;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_ok) begin
            step_q  <= step_sel;
            state_q <= S_MULD;
          end else begin
            done_q    <= 1'b1;
            status_q  <= STATUS_NORM_FAIL;
            cal_out_q <= '0;
            lsb_out_q <= '0;
            fs_out_q  <= '0;
            state_q   <= S_IDLE;
          end
        end
        S_MULD: begin
          prod_q  <= mul_p;
          state_q <= S_MULL;
        end
        S_MULL: begin
          den_q   <= prod_q[DEN_W-1:0];
          prod_q  <= mul_p;
          state_q <= S_LOADC;
        end
        S_LOADC: begin
          if (norm_q) begin
            lsb_q <= prod_q << LSB_FRAC_SHIFT;
            fs_q  <= FS_W'(step_q) << FS_SHIFT;
          end else begin
            lsb_q <= prod_q;
            fs_q  <= FS_W'(cur_q);
          end
          state_q <= S_DIVC;
        end
        S_DIVC: begin
          if (div_done) begin
            cal_q   <= div_quo;
            state_q <= S_HALVE;
          end
        end
        S_HALVE: begin
          if (cal_q > CAL_MAX) begin
            cal_q <= cal_q >> 1;
            lsb_q <= lsb_q << 1;
            fs_q  <= fs_q << 1;
          end else begin
            done_q    <= 1'b1;
            status_q  <= STATUS_OK;
            cal_out_q <= cal_q[CAL_W-1:0];
            lsb_out_q <= lsb_q[LSB_W+LSB_FRAC_SHIFT-1:LSB_FRAC_SHIFT];
            fs_out_q  <= fs_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign cfg_ready_o      = (state_q == S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign calibration_o    = cal_out_q;
  assign current_lsb_pa_o = lsb_out_q;
  assign full_scale_ua_o  = fs_out_q;

endmodule

// File: tb/tb_shunt_monitor_calibration.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shunt_monitor_calibration
// Self-checking bench for the shunt monitor calibration block. A directed
// table covers check order, field extremes and the 1-2-5 series limits, then
// random phases with fresh shunt settings send bursty requests. Results are
// checked against an in-bench integer model, typed rows against a status.
// ----------------------------------------------------------------------------
module tb_shunt_monitor_calibration;
  import smc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 120;
  localparam int MAX_REPORTS    = 50;
  localparam int DIR_ROWS       = 25;
  localparam int unsigned STEP_SERIES [12] = '{
    1, 2, 5, 10, 20, 50, 100, 200, 500, 1000, 2000, 5000
  };

  typedef struct packed {
    status_e            status;
    logic [CAL_W-1:0]   cal;
    logic [LSB_W-1:0]   lsb_pa;
    logic [FS_W-1:0]    fs_ua;
  } cal_result_t;

  typedef struct packed {
    logic [RES_W-1:0] shunt;
    logic [RES_W-1:0] floor_ohm;
    logic [CUR_W-1:0] cur;
    logic             norm;
    logic             typed;
    status_e          status;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CUR_W-1:0]    max_current_ua_i = '0;
  logic                normalize_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = CFG_SHUNT;
  logic [RES_W-1:0]    cfg_data_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [CAL_W-1:0]    calibration_o;
  logic [LSB_W-1:0]    current_lsb_pa_o;
  logic [FS_W-1:0]     full_scale_ua_o;

  cal_result_t      pending_cal [$];
  logic [RES_W-1:0] shunt_cfg = SHUNT_RESET;
  logic [RES_W-1:0] min_cfg = MIN_SHUNT_RESET;
  int               mismatch_count = 0;
  int               idle_cycles = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{24'd100000, 24'd1000, 32'd0, 1'b0, 1'b1, STATUS_CURRENT_LOW},
    '{24'd100000, 24'd1000, 32'd999, 1'b1, 1'b1, STATUS_CURRENT_LOW},
    '{24'd100000, 24'd1000, 32'd1000, 1'b0, 1'b0, STATUS_OK},
    '{24'd100000, 24'd1000, 32'd1000, 1'b1, 1'b0, STATUS_OK},
    '{24'd100000, 24'd1000, 32'd819000, 1'b0, 1'b0, STATUS_OK},
    '{24'd100000, 24'd1000, 32'd819001, 1'b1, 1'b1, STATUS_VSHUNT_HIGH},
    '{24'd100000, 24'd1000, 32'hFFFFFFFF, 1'b0, 1'b1, STATUS_VSHUNT_HIGH},
    '{24'd100000, 24'd1000, 32'd65536, 1'b1, 1'b0, STATUS_OK},
    '{24'd100000, 24'd1000, 32'd500000, 1'b1, 1'b0, STATUS_OK},
    '{24'd1, 24'd1000, 32'd5000, 1'b0, 1'b1, STATUS_SHUNT_LOW},
    '{24'd0, 24'd0, 32'd5000, 1'b1, 1'b1, STATUS_SHUNT_LOW},
    '{24'd0, 24'd0, 32'hFFFFFFFF, 1'b0, 1'b1, STATUS_SHUNT_LOW},
    '{24'd0, 24'd0, 32'd999, 1'b0, 1'b1, STATUS_CURRENT_LOW},
    '{24'd400, 24'd0, 32'd163840000, 1'b1, 1'b1, STATUS_NORM_FAIL},
    '{24'd400, 24'd0, 32'd163839999, 1'b1, 1'b0, STATUS_OK},
    '{24'd400, 24'd0, 32'd163840000, 1'b0, 1'b0, STATUS_OK},
    '{24'd31, 24'd0, 32'd1000, 1'b1, 1'b1, STATUS_NORM_FAIL},
    '{24'd32, 24'd0, 32'd1000, 1'b1, 1'b0, STATUS_OK},
    '{24'd1, 24'd0, 32'hFFFFFFFF, 1'b0, 1'b0, STATUS_OK},
    '{24'd1, 24'd0, 32'd1000, 1'b0, 1'b0, STATUS_OK},
    '{24'd1, 24'd0, 32'd1000, 1'b1, 1'b1, STATUS_NORM_FAIL},
    '{24'hFFFFFF, 24'hFFFFFF, 32'd4881, 1'b1, 1'b0, STATUS_OK},
    '{24'hFFFFFF, 24'hFFFFFF, 32'd4882, 1'b0, 1'b1, STATUS_VSHUNT_HIGH},
    '{24'hFFFFFF, 24'hFFFFFF, 32'd1000, 1'b0, 1'b0, STATUS_OK},
    '{24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, STATUS_VSHUNT_HIGH}
  };

  shunt_monitor_calibration dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .max_current_ua_i (max_current_ua_i),
    .normalize_i      (normalize_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .calibration_o    (calibration_o),
    .current_lsb_pa_o (current_lsb_pa_o),
    .full_scale_ua_o  (full_scale_ua_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic cal_result_t calc_setup(input logic [CUR_W-1:0] cur, input logic norm,
                                             input logic [RES_W-1:0] shunt,
                                             input logic [RES_W-1:0] shunt_min);
    logic [63:0] r, c, a, b, s, step, cal, fs, lsb, num;
    cal_result_t res;
    r = 64'(shunt);
    c = 64'(cur);
    cal = '0;
    fs = '0;
    lsb = '0;
    res.status = STATUS_OK;
    if (c * r > 64'd81900000000) begin
      res.status = STATUS_VSHUNT_HIGH;
    end else if (c < 64'd1000) begin
      res.status = STATUS_CURRENT_LOW;
    end else if (r == 0 || shunt < shunt_min) begin
      res.status = STATUS_SHUNT_LOW;
    end else if (norm) begin
      a = c >> 15;
      b = 64'd156250 / r;
      s = ((a > b) ? a : b) + 64'd1;
      step = '0;
      for (int i = 0; i < 12; i++) begin
        if (step == 0 && 64'(STEP_SERIES[i]) >= s) step = 64'(STEP_SERIES[i]);
      end
      if (step == 0) begin
        res.status = STATUS_NORM_FAIL;
      end else begin
        cal = (64'd10240000000 + step * r) / (64'd2 * step * r);
        fs = step << 15;
        lsb = step * 64'd1000000;
        while (cal > 64'd32767) begin
          cal = cal >> 1;
          fs = fs << 1;
          lsb = lsb << 1;
        end
      end
    end else begin
      num = c * 64'd15625;
      cal = (64'd335544320000000 + c * r) / (64'd2 * c * r);
      fs = c;
      while (cal > 64'd32767) begin
        cal = cal >> 1;
        fs = fs << 1;
        num = num << 1;
      end
      lsb = num >> 9;
    end
    res.cal = cal[CAL_W-1:0];
    res.lsb_pa = lsb[LSB_W-1:0];
    res.fs_ua = fs[FS_W-1:0];
    return res;
  endfunction

  function automatic logic [CUR_W-1:0] pick_current(input logic [RES_W-1:0] r);
    logic [63:0] lim, hi, v;
    int mode;
    lim = (r == 0) ? 64'hFFFFFFFF : 64'd81900000000 / 64'(r);
    hi = (lim > 64'hFFFFFFFF) ? 64'hFFFFFFFF : lim;
    mode = $urandom_range(0, 15);
    if (mode == 0) begin
      v = 64'($urandom());
    end else if (mode == 1) begin
      v = 64'($urandom_range(0, 999));
    end else if (mode == 2) begin
      v = lim + 64'($urandom_range(0, 1));
      if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
    end else if (mode == 3) begin
      v = 64'($urandom_range(998, 1001));
    end else begin
      v = 64'($urandom()) & ((64'd1 << $urandom_range(10, 32)) - 64'd1);
      if (hi < 64'd1000) v = 64'($urandom());
      else if (v < 64'd1000 || v > hi) v = 64'd1000 + v % (hi - 64'd999);
    end
    return v[CUR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic issue_request(input logic [CUR_W-1:0] cur, input logic norm,
                               input logic typed, input status_e typed_status);
    cal_result_t want;
    start <= 1'b1;
    max_current_ua_i <= cur;
    normalize_i <= norm;
    do @(posedge clk_i); while (busy);
    if (typed) begin
      want = '0;
      want.status = typed_status;
    end else begin
      want = calc_setup(cur, norm, shunt_cfg, min_cfg);
    end
    pending_cal.push_back(want);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_cal.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [RES_W-1:0] shunt, input logic [RES_W-1:0] floor_ohm);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SHUNT;
    cfg_data_i <= shunt;
    do @(posedge clk_i); while (!cfg_ready_o);
    shunt_cfg = shunt;
    cfg_index_i <= CFG_MIN_SHUNT;
    cfg_data_i <= floor_ohm;
    do @(posedge clk_i); while (!cfg_ready_o);
    min_cfg = floor_ohm;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cal_result_t want;
    if (rst_ni && done_o) begin
      if (pending_cal.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 64'(status_o));
      end else begin
        want = pending_cal.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 64'(want.status), 64'(status_o));
        if (calibration_o !== want.cal)
          report_mismatch("calibration", 64'(want.cal), 64'(calibration_o));
        if (current_lsb_pa_o !== want.lsb_pa)
          report_mismatch("current_lsb_pa", 64'(want.lsb_pa), 64'(current_lsb_pa_o));
        if (full_scale_ua_o !== want.fs_ua)
          report_mismatch("full_scale_ua", 64'(want.fs_ua), 64'(full_scale_ua_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [RES_W-1:0] shunt, floor_ohm;
    int burst_left, gap, k;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].shunt != shunt_cfg || dir_rows[i].floor_ohm != min_cfg) begin
        drain_results();
        apply_config(dir_rows[i].shunt, dir_rows[i].floor_ohm);
      end
      issue_request(dir_rows[i].cur, dir_rows[i].norm, dir_rows[i].typed, dir_rows[i].status);
    end

    for (int p = 0; p < PHASES; p++) begin
      k = $urandom_range(1, 24);
      shunt = RES_W'((32'd1 << (k - 1)) | ($urandom() & ((32'd1 << (k - 1)) - 1)));
      if ($urandom_range(0, 7) == 0) shunt = '1;
      case ($urandom_range(0, 5))
        0: floor_ohm = '0;
        1: floor_ohm = RES_W'($urandom_range(32'(shunt), 32'hFFFFFF));
        2: floor_ohm = shunt;
        default: floor_ohm = RES_W'($urandom_range(0, 32'(shunt)));
      endcase
      drain_results();
      apply_config(shunt, floor_ohm);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 39) begin
          drain_results();
        end else if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                            : $urandom_range(1, 10);
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        if (burst_left > 0) burst_left--;
        issue_request(pick_current(shunt_cfg), 1'($urandom_range(0, 1)), 1'b0, STATUS_OK);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_cal.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/smc_pkg.sv
hw/rtl/smc_div.sv
hw/rtl/shunt_monitor_calibration.sv
tb/tb_shunt_monitor_calibration.sv
